// ----- hw/rtl/rshe_pkg.sv -----
// Shared types, constants and coefficient tables for the spherical harmonic evaluator.
package rshe_pkg;

  localparam int L_MAX = 15;
  localparam int InTdataW = 48;
  localparam int OutTdataW = 24;
  localparam int CoefW = 34;
  localparam int QueueDepth = 2;
  localparam int DivSteps = 9;
  localparam int TaylorSteps = 7;

  localparam logic [30:0] PiHalfQ30 = 31'd1686629713;
  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;
  localparam logic signed [35:0] InvSqrt4PiQ28 = 36'sd75724244;
  localparam logic signed [71:0] ValMax = 72'sd4194303;
  localparam logic signed [71:0] ValMin = -72'sd4194304;

  typedef logic [7:0] tdiv_t;
  localparam tdiv_t TaylorDiv [0:7] = '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2,
                                         8'd1};

  typedef struct packed {
    logic        exceed;
    logic        flip;
    logic [3:0]  deg;
    logic [3:0]  ma;
    logic [15:0] polar;
    logic [15:0] azim;
  } rshe_item_t;

  typedef enum logic [3:0] {
    C_IDLE, C_ANGLE, C_SQUARE, C_INIT, C_MUL, C_LOAD, C_DIV, C_STEP, C_DONE
  } cos_state_t;

  typedef enum logic [4:0] {
    E_IDLE, E_XWAIT, E_SWAIT, E_MCHK,
    E_MA_MUL, E_MA_TAKE, E_MB_MUL, E_MB_TAKE,
    E_PA_MUL, E_PA_TAKE, E_PB_MUL, E_PB_TAKE,
    E_RCHK, E_RA_MUL, E_RA_TAKE, E_RB_MUL, E_RB_TAKE, E_RC_MUL, E_RC_TAKE,
    E_CMWAIT, E_Y_MUL, E_Y_TAKE, E_DONE
  } eng_state_t;

  typedef logic [CoefW-1:0] coef_t;
  typedef coef_t [15:0] coef_vec_t;
  typedef coef_vec_t [15:0] coef_tab_t;

  // floor(sqrt(floor(n * 2^56 / d))) in Q28
  function automatic coef_t sqrt_ratio(input logic [31:0] n, input logic [31:0] d);
    logic [87:0] num;
    logic [87:0] q;
    logic [32:0] rem;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_v;
    if (d == 32'd0) begin
      return '0;
    end
    num = {n, 56'd0};
    q = '0;
    rem = '0;
    for (int i = 87; i >= 0; i--) begin
      rem = {rem[31:0], num[i]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    v = q[63:0];
    res = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return coef_t'(res);
  endfunction

  function automatic coef_vec_t build_cs();
    coef_vec_t t;
    t = '0;
    for (int k = 1; k < 16; k++) begin
      t[k] = sqrt_ratio(32'(2 * k + 1), 32'(2 * k));
    end
    return t;
  endfunction

  function automatic coef_vec_t build_c1();
    coef_vec_t t;
    t = '0;
    for (int m = 0; m < 16; m++) begin
      t[m] = sqrt_ratio(32'(2 * m + 3), 32'd1);
    end
    return t;
  endfunction

  function automatic coef_tab_t build_ca();
    coef_tab_t t;
    t = '0;
    for (int m = 0; m < 16; m++) begin
      for (int l = 0; l < 16; l++) begin
        if (l >= m + 2) begin
          t[m][l] = sqrt_ratio(32'((2 * l + 1) * (2 * l - 1)), 32'((l - m) * (l + m)));
        end
      end
    end
    return t;
  endfunction

  function automatic coef_tab_t build_cb();
    coef_tab_t t;
    t = '0;
    for (int m = 0; m < 16; m++) begin
      for (int l = 0; l < 16; l++) begin
        if (l >= m + 2) begin
          t[m][l] = sqrt_ratio(32'((2 * l + 1) * (l + m - 1) * (l - m - 1)),
                               32'((2 * l - 3) * (l - m) * (l + m)));
        end
      end
    end
    return t;
  endfunction

  localparam coef_vec_t CoefS = build_cs();
  localparam coef_vec_t CoefC1 = build_c1();
  localparam coef_tab_t CoefA = build_ca();
  localparam coef_tab_t CoefB = build_cb();

endpackage

// ----- hw/rtl/real_spherical_harmonic_eval_top.sv -----
// Latency from input accept to output valid is set by the shared cosine unit
//   (three cosines per item, each of seven Taylor steps with a radix-16 constant divider)
//   and by the recurrence sequencer, which runs longest for order zero, degree 15.
// An item with order beyond degree bypasses the cosine unit and the recurrence.
// Throughput: one item in the engine at a time; a two-entry queue takes items meanwhile.
// Reset: synchronous, active high; clears queue, sequencers and output valid.
module real_spherical_harmonic_eval_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // degree[3:0], order[8:4], polar_angle[24:9], azimuth[40:25], zero fill
  input  logic [rshe_pkg::InTdataW-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // harmonic_value[22:0], zero fill
  output logic [rshe_pkg::OutTdataW-1:0] m_tdata,
  // order_exceeds_degree[0]
  output logic                           m_tuser
);
  import rshe_pkg::*;

  rshe_item_t f_item;
  rshe_item_t q_head;
  logic       q_full;
  logic       q_push;
  logic       q_valid;
  logic       q_pop;

  rshe_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (f_item)
  );

  rshe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  rshe_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- hw/rtl/rshe_front.sv -----
// Input classification: clamp degree, fold order sign, flag order beyond degree.
module rshe_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [rshe_pkg::InTdataW-1:0] s_tdata,
  input  logic                         q_full,
  output logic                         q_push,
  output rshe_pkg::rshe_item_t         q_item
);
  import rshe_pkg::*;

  logic [3:0] deg_in;
  logic [4:0] ord_in;
  logic [4:0] ma5;
  logic [3:0] deg_eff;

  always_comb begin
    deg_in = s_tdata[3:0];
    ord_in = s_tdata[8:4];
    ma5 = ord_in[4] ? 5'(-ord_in) : ord_in;
    deg_eff = (32'(deg_in) > L_MAX) ? 4'(L_MAX) : deg_in;
    q_item.exceed = ma5 > {1'b0, deg_eff};
    q_item.flip = ord_in[4] & ma5[0];
    q_item.deg = deg_eff;
    q_item.ma = ma5[3:0];
    q_item.polar = s_tdata[24:9];
    q_item.azim = s_tdata[40:25];
  end

  assign s_tready = !q_full;
  assign q_push = s_tvalid && !q_full;

endmodule

// ----- hw/rtl/rshe_fifo.sv -----
// Two-entry item queue between front and engine.
module rshe_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rshe_pkg::rshe_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output rshe_pkg::rshe_item_t head
);
  import rshe_pkg::*;

  rshe_item_t mem [QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = count == 2'(QueueDepth);
  assign valid = count != 2'd0;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hw/rtl/rshe_cos.sv -----
// Iterative Q30 cosine of a 17-bit turn index: quadrant fold, Taylor steps, constant divider.
module rshe_cos (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [16:0]        angle,
  output logic               done,
  output logic signed [31:0] value
);
  import rshe_pkg::*;

  cos_state_t         state;
  cos_state_t         state_next;
  logic [15:0]        rr;
  logic               neg;
  logic [63:0]        prod;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [31:0]        a2;
  logic signed [31:0] t;
  logic signed [31:0] t_new;
  logic [2:0]         idx;
  logic [35:0]        dvd;
  logic [35:0]        dvd_next;
  logic [7:0]         rem;
  logic [7:0]         rem_next;
  logic [3:0]         dcnt;
  logic               take;

  assign take = (state == C_IDLE || state == C_DONE) && start;

  always_comb begin
    unique case (state)
      C_IDLE:   state_next = start ? C_ANGLE : C_IDLE;
      C_ANGLE:  state_next = C_SQUARE;
      C_SQUARE: state_next = C_INIT;
      C_INIT:   state_next = C_MUL;
      C_MUL:    state_next = C_LOAD;
      C_LOAD:   state_next = C_DIV;
      C_DIV:    state_next = (dcnt == 4'(DivSteps - 1)) ? C_STEP : C_DIV;
      C_STEP:   state_next = (idx == 3'(TaylorSteps - 1)) ? C_DONE : C_MUL;
      C_DONE:   state_next = start ? C_ANGLE : C_IDLE;
      default:  state_next = C_IDLE;
    endcase
  end

  always_comb begin
    done = state == C_DONE;
    unique case (state)
      C_ANGLE: begin
        mul_a = {16'd0, rr};
        mul_b = {1'b0, PiHalfQ30};
      end
      C_SQUARE: begin
        mul_a = prod[46:15];
        mul_b = prod[46:15];
      end
      C_MUL: begin
        mul_a = a2;
        mul_b = 32'(t);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    logic [8:0] trial;
    logic [7:0] dv;
    dv = TaylorDiv[idx];
    rem_next = rem;
    dvd_next = dvd;
    for (int j = 0; j < 4; j++) begin
      trial = {rem_next, dvd_next[35]};
      dvd_next = {dvd_next[34:0], 1'b0};
      if (trial >= {1'b0, dv}) begin
        rem_next = 8'(trial - {1'b0, dv});
        dvd_next[0] = 1'b1;
      end else begin
        rem_next = trial[7:0];
      end
    end
    t_new = OneQ30 - $signed({1'b0, dvd[30:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (take) begin
      rr <= angle[15] ? 16'(17'd32768 - {2'b0, angle[14:0]}) : {1'b0, angle[14:0]};
      neg <= angle[16] ^ angle[15];
    end
    unique case (state)
      C_INIT: begin
        a2 <= prod[61:30];
        t <= OneQ30;
        idx <= '0;
      end
      C_LOAD: begin
        dvd <= {2'b0, prod[63:30]};
        rem <= '0;
        dcnt <= '0;
      end
      C_DIV: begin
        dvd <= dvd_next;
        rem <= rem_next;
        dcnt <= dcnt + 4'd1;
      end
      C_STEP: begin
        t <= t_new;
        idx <= idx + 3'd1;
        value <= neg ? -t_new : t_new;
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/rshe_engine.sv -----
// Back end: Legendre recurrence, azimuth factor, rounding and the output register.
module rshe_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  rshe_pkg::rshe_item_t           q_head,
  output logic                           q_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rshe_pkg::OutTdataW-1:0] m_tdata,
  output logic                           m_tuser
);
  import rshe_pkg::*;

  eng_state_t         state;
  eng_state_t         state_next;
  logic [3:0]         deg;
  logic [3:0]         ma;
  logic               flip;
  logic [15:0]        polar;
  logic [15:0]        azim;
  logic signed [31:0] x;
  logic signed [31:0] s;
  logic signed [31:0] cm;
  logic signed [35:0] p;
  logic signed [35:0] p1;
  logic signed [35:0] c;
  logic signed [71:0] prod;
  logic signed [35:0] mul_a;
  logic signed [35:0] mul_b;
  logic [4:0]         k;
  logic [4:0]         ll;
  logic [22:0]        res_val;
  logic               res_flag;
  logic               out_free;
  logic               cos_start;
  logic [16:0]        cos_angle;
  logic               cos_done;
  logic signed [31:0] cos_value;
  logic [15:0]        cm_turn;
  logic signed [71:0] tr30;
  logic signed [71:0] tr28;
  logic [22:0]        y_sat;

  function automatic logic signed [71:0] trunc_sh(input logic signed [71:0] v,
                                                  input logic [4:0] sh);
    logic signed [71:0] bias;
    bias = v[71] ? ((72'sd1 <<< sh) - 72'sd1) : 72'sd0;
    return (v + bias) >>> sh;
  endfunction

  rshe_cos u_cos (
    .clk   (clk),
    .rst   (rst),
    .start (cos_start),
    .angle (cos_angle),
    .done  (cos_done),
    .value (cos_value)
  );

  assign out_free = !m_tvalid || m_tready;
  assign cm_turn = 16'({12'd0, ma} * {4'd0, azim});
  assign tr30 = trunc_sh(prod, 5'd30);
  assign tr28 = trunc_sh(prod, 5'd28);

  always_comb begin
    logic signed [71:0] yf;
    logic signed [71:0] ym;
    logic signed [71:0] yr;
    yf = flip ? -tr30 : tr30;
    ym = yf[71] ? -yf : yf;
    yr = (ym + 72'sd128) >>> 8;
    yr = yf[71] ? -yr : yr;
    if (yr > ValMax) begin
      y_sat = ValMax[22:0];
    end else if (yr < ValMin) begin
      y_sat = ValMin[22:0];
    end else begin
      y_sat = yr[22:0];
    end
  end

  always_comb begin
    unique case (state)
      E_IDLE:    state_next = q_valid ? (q_head.exceed ? E_DONE : E_XWAIT) : E_IDLE;
      E_XWAIT:   state_next = cos_done ? E_SWAIT : E_XWAIT;
      E_SWAIT:   state_next = cos_done ? E_MCHK : E_SWAIT;
      E_MCHK: begin
        if (k <= {1'b0, ma}) begin
          state_next = E_MA_MUL;
        end else if (deg > ma) begin
          state_next = E_PA_MUL;
        end else begin
          state_next = E_CMWAIT;
        end
      end
      E_MA_MUL:  state_next = E_MA_TAKE;
      E_MA_TAKE: state_next = E_MB_MUL;
      E_MB_MUL:  state_next = E_MB_TAKE;
      E_MB_TAKE: state_next = E_MCHK;
      E_PA_MUL:  state_next = E_PA_TAKE;
      E_PA_TAKE: state_next = E_PB_MUL;
      E_PB_MUL:  state_next = E_PB_TAKE;
      E_PB_TAKE: state_next = E_RCHK;
      E_RCHK:    state_next = (ll <= {1'b0, deg}) ? E_RA_MUL : E_CMWAIT;
      E_RA_MUL:  state_next = E_RA_TAKE;
      E_RA_TAKE: state_next = E_RB_MUL;
      E_RB_MUL:  state_next = E_RB_TAKE;
      E_RB_TAKE: state_next = E_RC_MUL;
      E_RC_MUL:  state_next = E_RC_TAKE;
      E_RC_TAKE: state_next = E_RCHK;
      E_CMWAIT:  state_next = cos_done ? E_Y_MUL : E_CMWAIT;
      E_Y_MUL:   state_next = E_Y_TAKE;
      E_Y_TAKE:  state_next = E_DONE;
      E_DONE:    state_next = out_free ? E_IDLE : E_DONE;
      default:   state_next = E_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == E_IDLE) && q_valid;
    cos_start = ((state == E_IDLE) && q_valid && !q_head.exceed)
             || ((state == E_XWAIT) && cos_done)
             || ((state == E_MCHK) && (k > {1'b0, ma}) && !(deg > ma))
             || ((state == E_RCHK) && (ll > {1'b0, deg}));
    unique case (state)
      E_IDLE:  cos_angle = {1'b0, q_head.polar};
      E_XWAIT: cos_angle = {1'b0, polar} + 17'h18000;
      default: cos_angle = {cm_turn, 1'b0};
    endcase
    unique case (state)
      E_MA_MUL: begin
        mul_a = {2'b0, CoefS[k[3:0]]};
        mul_b = 36'(s);
      end
      E_MB_MUL, E_PB_MUL: begin
        mul_a = c;
        mul_b = p;
      end
      E_PA_MUL: begin
        mul_a = {2'b0, CoefC1[ma]};
        mul_b = 36'(x);
      end
      E_RA_MUL: begin
        mul_a = {2'b0, CoefA[ma][ll[3:0]]};
        mul_b = 36'(x);
      end
      E_RB_MUL: begin
        mul_a = c;
        mul_b = p1;
      end
      E_RC_MUL: begin
        mul_a = {2'b0, CoefB[ma][ll[3:0]]};
        mul_b = p;
      end
      E_Y_MUL: begin
        mul_a = p;
        mul_b = 36'(cm);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      E_IDLE: begin
        if (q_valid) begin
          deg <= q_head.deg;
          ma <= q_head.ma;
          flip <= q_head.flip;
          polar <= q_head.polar;
          azim <= q_head.azim;
          res_val <= '0;
          res_flag <= q_head.exceed;
        end
      end
      E_XWAIT: begin
        if (cos_done) begin
          x <= cos_value;
        end
      end
      E_SWAIT: begin
        if (cos_done) begin
          s <= cos_value;
          p <= InvSqrt4PiQ28;
          k <= 5'd1;
        end
      end
      E_MA_TAKE, E_PA_TAKE, E_RA_TAKE: c <= 36'(tr30);
      E_MB_TAKE: begin
        p <= 36'(-tr28);
        k <= k + 5'd1;
      end
      E_PB_TAKE: begin
        p1 <= 36'(tr28);
        ll <= {1'b0, ma} + 5'd2;
      end
      E_RCHK: begin
        if (ll > {1'b0, deg}) begin
          p <= p1;
        end
      end
      E_RB_TAKE: c <= 36'(tr28);
      E_RC_TAKE: begin
        p <= p1;
        p1 <= c - 36'(tr28);
        ll <= ll + 5'd1;
      end
      E_CMWAIT: begin
        if (cos_done) begin
          cm <= cos_value;
        end
      end
      E_Y_TAKE: begin
        res_val <= y_sat;
        res_flag <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == E_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_DONE && out_free) begin
      m_tdata <= {1'b0, res_val};
      m_tuser <= res_flag;
    end
  end

endmodule

// ----- hw/rtl/rshe_checker.sv -----
// Port-level checks for the spherical harmonic evaluator, bound to the top level.
module rshe_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [rshe_pkg::InTdataW-1:0]  s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [rshe_pkg::OutTdataW-1:0] m_tdata,
  input logic                           m_tuser
);
  import rshe_pkg::*;

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("flagged item carries nonzero value");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
    else $error("output item changed while stalled");

endmodule

bind real_spherical_harmonic_eval_top rshe_checker u_rshe_checker (.*);

// ----- test/real_spherical_harmonic_eval_checker.sv -----
// Checker for the spherical harmonic evaluator: predicts each result and compares.
`timescale 1ns / 1ps
module real_spherical_harmonic_eval_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  input  logic                                  s_tready,
  input  logic [rshe_pkg::InTdataW-1:0]         s_tdata,
  input  logic                                  m_tvalid,
  input  logic                                  m_tready,
  input  logic [rshe_pkg::OutTdataW-1:0]        m_tdata,
  input  logic                                  m_tuser,
  output int                                    fail_count,
  output int                                    pending
);

  typedef struct packed {
    logic [22:0] value;
    logic        exceed;
  } harmonic_t;

  harmonic_t harmonic_q[$];

  localparam longint PiHalf = 64'd1686629713;
  localparam longint OneQ = 64'sd1073741824;
  localparam longint InvSqrt4Pi = 64'sd75724244;

  function automatic longint trunc_mul(longint a, longint b, int shift);
    longint p;
    longint d;
    p = a * b;
    d = longint'(1) <<< shift;
    return p / d;
  endfunction

  function automatic longint quarter_cos(longint r);
    longint taylor [7];
    longint a;
    longint a2;
    longint t;
    taylor = '{182, 132, 90, 56, 30, 12, 2};
    a = (r * PiHalf) >>> 15;
    a2 = (a * a) >>> 30;
    t = OneQ;
    for (int i = 0; i < 7; i++) begin
      t = OneQ - (a2 * t) / (taylor[i] <<< 30);
    end
    return t;
  endfunction

  function automatic longint turn_cos(logic [16:0] u);
    longint r;
    r = longint'(u[14:0]);
    case (u[16:15])
      2'd0: return quarter_cos(r);
      2'd1: return -quarter_cos(32768 - r);
      2'd2: return -quarter_cos(r);
      default: return quarter_cos(32768 - r);
    endcase
  endfunction

  function automatic longint root_ratio(longint n, longint d);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    if (d == 0) return 0;
    q = n / d;
    rem = n % d;
    for (int i = 0; i < 56; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q[0] = 1'b1;
      end
    end
    v = q;
    res = 0;
    bt = 64'h4000_0000_0000_0000;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return longint'(res);
  endfunction

  function automatic harmonic_t eval_harmonic(logic [47:0] d);
    harmonic_t h;
    longint l;
    longint ma;
    longint x;
    longint s;
    longint p;
    longint p1;
    longint pn;
    longint c;
    longint ca;
    longint cb;
    longint dd;
    longint cm;
    longint y;
    longint v;
    logic [4:0] ov;
    logic [15:0] th;
    logic [15:0] az;
    logic [15:0] ang;
    logic flip;
    l = longint'(d[3:0]);
    ov = d[8:4];
    th = d[24:9];
    az = d[40:25];
    ma = ov[4] ? 32 - longint'(ov) : longint'(ov);
    flip = ov[4] && ma[0];
    if (l > rshe_pkg::L_MAX) l = rshe_pkg::L_MAX;
    h = '0;
    if (ma > l) begin
      h.exceed = 1'b1;
      return h;
    end
    x = turn_cos({1'b0, th});
    s = turn_cos(17'({1'b0, th} + 17'h18000));
    p = InvSqrt4Pi;
    for (longint k = 1; k <= ma; k++) begin
      c = trunc_mul(root_ratio(2 * k + 1, 2 * k), s, 30);
      p = -trunc_mul(c, p, 28);
    end
    if (l > ma) begin
      p1 = trunc_mul(trunc_mul(root_ratio(2 * ma + 3, 1), x, 30), p, 28);
      for (longint ll = ma + 2; ll <= l; ll++) begin
        dd = (ll - ma) * (ll + ma);
        ca = root_ratio((2 * ll + 1) * (2 * ll - 1), dd);
        cb = root_ratio((2 * ll + 1) * (ll + ma - 1) * (ll - ma - 1), (2 * ll - 3) * dd);
        pn = trunc_mul(trunc_mul(ca, x, 30), p1, 28) - trunc_mul(cb, p, 28);
        p = p1;
        p1 = pn;
      end
      p = p1;
    end
    ang = 16'(ma * longint'(az));
    cm = turn_cos({ang, 1'b0});
    y = trunc_mul(p, cm, 30);
    if (flip) y = -y;
    if (y >= 0) v = (y + 128) / 256;
    else v = -((-y + 128) / 256);
    if (v > 4194303) v = 4194303;
    if (v < -4194304) v = -4194304;
    h.value = v[22:0];
    return h;
  endfunction

  assign pending = harmonic_q.size();

  always @(posedge clk) begin
    harmonic_t want;
    int errs;
    errs = 0;
    if (rst) begin
      harmonic_q.delete();
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) harmonic_q.push_back(eval_harmonic(s_tdata));
      if (m_tvalid && m_tready) begin
        if (harmonic_q.size() == 0) begin
          $error("unexpected item: value %0d", $signed(m_tdata[22:0]));
          errs = errs + 1;
        end else begin
          want = harmonic_q.pop_front();
          if (m_tdata[22:0] !== want.value) begin
            $error("harmonic_value expected %0d actual %0d", $signed(want.value),
                   $signed(m_tdata[22:0]));
            errs = errs + 1;
          end
          if (m_tuser !== want.exceed) begin
            $error("order_exceeds_degree expected %0d actual %0d", want.exceed, m_tuser);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ----- test/real_spherical_harmonic_eval_top_test.sv -----
// Testbench top for the spherical harmonic evaluator: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module real_spherical_harmonic_eval_top_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [rshe_pkg::InTdataW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [rshe_pkg::OutTdataW-1:0] m_tdata;
  logic m_tuser;
  int fail_count;
  int pending;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  localparam int RandomItems = 630;
  localparam int CycleLimit = 2_000_000;

  always #6 clk = ~clk;

  real_spherical_harmonic_eval_top uut (.*);

  real_spherical_harmonic_eval_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    int n;
    bit hold_done;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off && !hold_done) begin
        m_tready <= 1'b0;
        repeat (1500) @(negedge clk);
        hold_done = 1'b1;
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  task automatic send_item(input logic [3:0] deg, input logic [4:0] ord,
                           input logic [15:0] pol, input logic [15:0] az);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      n = $urandom_range(1, 9);
      repeat (n) @(negedge clk);
    end
    s_tdata <= {7'd0, az, pol, ord, deg};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [3:0] deg;
    logic [4:0] ord;
    int m;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_item(4'd0, 5'd0, 16'd0, 16'd0);
    send_item(4'd15, 5'd15, 16'hFFFF, 16'hFFFF);
    send_item(4'd15, 5'h11, 16'h8000, 16'h4000);
    send_item(4'd15, 5'h10, 16'h1234, 16'h5678);
    send_item(4'd3, 5'd4, 16'h4000, 16'd0);
    send_item(4'd2, 5'h1E, 16'h2000, 16'h2AAA);
    send_item(4'd15, 5'd0, 16'h0001, 16'hFFFF);
    send_item(4'd15, 5'd0, 16'h7FFF, 16'h0000);
    send_item(4'd7, 5'h19, 16'hC000, 16'hAAAA);
    send_item(4'd1, 5'h1F, 16'h5555, 16'h8000);
    send_item(4'd10, 5'd10, 16'h0800, 16'h0101);
    send_item(4'd0, 5'd1, 16'h3000, 16'h1000);
    hold_off = 1'b1;
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems - 60) calm = 1'b1;
      deg = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 7) == 0) begin
        ord = 5'($urandom);
      end else begin
        m = $urandom_range(0, deg);
        ord = $urandom_range(0, 1) ? 5'(-m) : 5'(m);
      end
      send_item(deg, ord, 16'($urandom), 16'($urandom));
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- real_spherical_harmonic_eval_top.f -----
hw/rtl/rshe_pkg.sv
hw/rtl/rshe_front.sv
hw/rtl/rshe_fifo.sv
hw/rtl/rshe_cos.sv
hw/rtl/rshe_engine.sv
hw/rtl/real_spherical_harmonic_eval_top.sv
hw/rtl/rshe_checker.sv
test/real_spherical_harmonic_eval_checker.sv
test/real_spherical_harmonic_eval_top_test.sv
